// File: sv/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg: shared constants for the axis permute reorder block
// Field widths, command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package apr_pkg;

  localparam int DATA_W     = 64;
  localparam int EXT_W      = 13;
  localparam int CTR_W      = 13;
  localparam int MAP_W      = 12;
  localparam int FIELD_W    = 3;
  localparam int MAX_AXES   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int DEPTH_DEFAULT = 4096;
  localparam int AXES_DEFAULT  = 4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  localparam logic [EXT_W-1:0] EXT_RESET = 13'd1;
  localparam logic [MAP_W-1:0] MAP_RESET = 12'd1672;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXTENT_0 = 3'd0,
    REG_EXTENT_1 = 3'd1,
    REG_EXTENT_2 = 3'd2,
    REG_EXTENT_3 = 3'd3,
    REG_AXIS_MAP = 3'd4
  } reg_index_t;

endpackage

// File: sv/axis_permute_reorder.sv
// ----------------------------------------------------------------------------
// axis_permute_reorder: reorder a flattened array of up to four axes
// Buffers loaded elements and emits them in a permuted axis order.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: start/busy with cmd and value. A request is taken at a
//   rising edge with start high and busy low. cmd = load appends value to the
//   element buffer (dropped once DEPTH entries are held); cmd = emit returns
//   the next element in stored axis order.
//   Result channel: valid strobes for one cycle with out_value, padded, last.
//   The receiver cannot stall; results must be taken when shown.
//   Throughput: one request per cycle whenever busy is low. An emit request
//   passes the accept register, the stride settle hold, the stride multiply
//   stage, the sum and bound compare, the registered buffer read and the
//   result register before its result shows.
//   An emit gives no result when any stored axis has length zero or no
//   element is loaded. When the emit that yields last is accepted, the fill
//   count and the odometer return to zero.
//   Config: cfg_we/cfg_index/cfg_data write extents and the axis map; writes
//   take effect for requests accepted in the following cycle.
//   Reset (rst, synchronous): extents to 1, identity axis map, fill count and
//   odometer to zero, pipeline emptied. busy is high while rst is high. The
//   buffer is not cleared; entries are never read before they are loaded.
// ----------------------------------------------------------------------------
module axis_permute_reorder #(
  parameter int DEPTH = apr_pkg::DEPTH_DEFAULT,
  parameter int AXES  = apr_pkg::AXES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd,
  input  logic [apr_pkg::DATA_W-1:0]       value,
  // result channel
  output logic                             valid,
  output logic [apr_pkg::DATA_W-1:0]       out_value,
  output logic                             padded,
  output logic                             last,
  // configuration
  input  logic                             cfg_we,
  input  logic [apr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DATA_W = apr_pkg::DATA_W;
  localparam int EXT_W  = apr_pkg::EXT_W;
  localparam int CTR_W  = apr_pkg::CTR_W;
  localparam int NAX    = apr_pkg::MAX_AXES;
  localparam int FW     = apr_pkg::FIELD_W;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // buffer address
  localparam int LW     = $clog2(DEPTH + 1);                // fill count
  localparam int SW     = LW;                               // saturated stride
  localparam int SPW    = EXT_W + SW;                       // stride product
  localparam int PRW    = CTR_W + SW;                       // term product
  localparam int SUMW   = PRW + 2;                          // sum of four terms

  // Front stages: request as accepted plus the odometer snapshot.
  typedef struct packed {
    logic                      load;
    logic                      emit;
    logic [DATA_W-1:0]         value;
    logic [AW-1:0]             waddr;
    logic [NAX-1:0][CTR_W-1:0] ctr;
    logic [NAX-1:0]            present;
    logic [NAX-1:0][1:0]       axis;
    logic [LW-1:0]             lcnt;
    logic                      last;
  } front_t;

  // After the stride multiply.
  typedef struct packed {
    logic                    load;
    logic                    emit;
    logic [DATA_W-1:0]       value;
    logic [AW-1:0]           waddr;
    logic [NAX-1:0][PRW-1:0] term;
    logic [LW-1:0]           lcnt;
    logic                    last;
  } term_t;

  // Buffer access stage.
  typedef struct packed {
    logic              load;
    logic              emit;
    logic [DATA_W-1:0] value;
    logic [AW-1:0]     addr;
    logic              pad;
    logic              last;
  } access_t;

  typedef struct packed {
    logic emit;
    logic pad;
    logic last;
  } read_t;

  // Clamp a stride at DEPTH: any index that reaches DEPTH is padded anyway.
  function automatic logic [SW-1:0] sat(input logic [SPW-1:0] p);
    sat = (p >= SPW'(DEPTH)) ? SW'(DEPTH) : p[SW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [NAX-1:0][EXT_W-1:0]       ext;
  logic [apr_pkg::MAP_W-1:0]       axis_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NAX; k++) ext[k] <= apr_pkg::EXT_RESET;
      axis_map <= apr_pkg::MAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        apr_pkg::REG_EXTENT_0: ext[0]   <= cfg_data[EXT_W-1:0];
        apr_pkg::REG_EXTENT_1: ext[1]   <= cfg_data[EXT_W-1:0];
        apr_pkg::REG_EXTENT_2: ext[2]   <= cfg_data[EXT_W-1:0];
        apr_pkg::REG_EXTENT_3: ext[3]   <= cfg_data[EXT_W-1:0];
        apr_pkg::REG_AXIS_MAP: axis_map <= cfg_data[apr_pkg::MAP_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Row-major caller strides, saturated at DEPTH. st2 and st1 are registered
  // from the extents, st0 from st1; all settle before a new emit multiplies.
  // --------------------------------------------------------------------------
  logic [NAX-1:0][EXT_W-1:0] ext_eff;
  logic [SW-1:0]             st2_c;
  logic [SW-1:0]             st0, st1, st2;
  logic [NAX-1:0][SW-1:0]    stride;

  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      ext_eff[k] = (k < AXES) ? ext[k] : EXT_W'(1);
    end
    st2_c = sat(SPW'(ext_eff[3]));
  end

  always_ff @(posedge clk) begin
    st2 <= st2_c;
    st1 <= sat(SPW'(ext_eff[2]) * SPW'(st2_c));
    st0 <= sat(SPW'(ext_eff[1]) * SPW'(st1));
  end

  assign stride[0] = st0;
  assign stride[1] = st1;
  assign stride[2] = st2;
  assign stride[3] = SW'(1);

  // --------------------------------------------------------------------------
  // Request acceptance, stored shape and odometer
  // --------------------------------------------------------------------------
  logic                      accept;
  logic                      is_load, is_emit;
  logic [LW-1:0]             loaded_count, loaded_count_next;
  logic [NAX-1:0][CTR_W-1:0] ctr, ctr_next;
  logic [NAX-1:0][FW-1:0]    field;
  logic [NAX-1:0]            present;
  logic [NAX-1:0][EXT_W-1:0] shape;
  logic                      empty_shape;
  logic                      load_ok;
  logic                      go;
  logic                      carry;
  logic [NAX-1:0][CTR_W-1:0] ctr_adv;
  front_t                    s1_next;

  assign busy    = rst;
  assign accept  = start && !busy;
  assign is_load = accept && (cmd == apr_pkg::CMD_LOAD);
  assign is_emit = accept && (cmd == apr_pkg::CMD_EMIT);

  always_comb begin
    logic [CTR_W:0] c_inc;
    empty_shape = 1'b0;
    for (int i = 0; i < NAX; i++) begin
      field[i]   = axis_map[FW*i +: FW];
      present[i] = (i < AXES) && (int'(field[i]) < AXES);
      shape[i]   = present[i] ? ext[field[i][1:0]] : EXT_W'(1);
      if (shape[i] == '0) empty_shape = 1'b1;
    end

    // Advance the odometer, last stored axis fastest; wrap out-of-range counts.
    carry = 1'b1;
    for (int i = NAX - 1; i >= 0; i--) begin
      c_inc      = {1'b0, ctr[i]} + (CTR_W + 1)'(1);
      ctr_adv[i] = ctr[i];
      if (carry) begin
        if (c_inc < {1'b0, shape[i]}) begin
          ctr_adv[i] = c_inc[CTR_W-1:0];
          carry      = 1'b0;
        end else begin
          ctr_adv[i] = '0;
        end
      end
    end

    load_ok = loaded_count < LW'(DEPTH);
    go      = is_emit && !empty_shape && (loaded_count != '0);

    loaded_count_next = loaded_count;
    ctr_next          = ctr;
    if (is_load && load_ok) begin
      loaded_count_next = loaded_count + LW'(1);
    end
    if (go) begin
      ctr_next = ctr_adv;
      if (carry) begin
        loaded_count_next = '0;
        ctr_next          = '0;
      end
    end

    s1_next.load    = is_load && load_ok;
    s1_next.emit    = go;
    s1_next.value   = value;
    s1_next.waddr   = loaded_count[AW-1:0];
    s1_next.ctr     = ctr;
    s1_next.present = present;
    for (int i = 0; i < NAX; i++) s1_next.axis[i] = field[i][1:0];
    s1_next.lcnt    = loaded_count;
    s1_next.last    = carry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      ctr          <= '0;
    end else begin
      loaded_count <= loaded_count_next;
      ctr          <= ctr_next;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline: s1 accept, s2 hold for stride settle, s3 multiply, s4 sum and
  // bound check, s5 buffer access, then the result register.
  // --------------------------------------------------------------------------
  front_t  s1, s2;
  term_t   s3, s3_next;
  access_t s4, s4_next;
  read_t   s5;
  logic [DATA_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.load <= 1'b0;
      s1.emit <= 1'b0;
      s2.load <= 1'b0;
      s2.emit <= 1'b0;
    end else begin
      s1 <= s1_next;
      s2 <= s1;
    end
  end

  // Source index terms: counter times stride of the mapped caller axis.
  always_comb begin
    s3_next.load  = s2.load;
    s3_next.emit  = s2.emit;
    s3_next.value = s2.value;
    s3_next.waddr = s2.waddr;
    s3_next.lcnt  = s2.lcnt;
    s3_next.last  = s2.last;
    for (int i = 0; i < NAX; i++) begin
      s3_next.term[i] = s2.present[i]
                      ? PRW'(s2.ctr[i]) * PRW'(stride[s2.axis[i]])
                      : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.load <= 1'b0;
      s3.emit <= 1'b0;
    end else begin
      s3 <= s3_next;
    end
  end

  // Sum the terms and check against the fill count seen at acceptance.
  always_comb begin
    logic [SUMW-1:0] sum;
    sum = '0;
    for (int i = 0; i < NAX; i++) sum = sum + SUMW'(s3.term[i]);
    s4_next.load  = s3.load;
    s4_next.emit  = s3.emit;
    s4_next.value = s3.value;
    s4_next.pad   = sum >= SUMW'(s3.lcnt);
    s4_next.addr  = s3.load ? s3.waddr : sum[AW-1:0];
    s4_next.last  = s3.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.load <= 1'b0;
      s4.emit <= 1'b0;
    end else begin
      s4 <= s4_next;
    end
  end

  // Element buffer. Loads write at the same stage where emits read, so the
  // request order is kept even when a new fill starts behind a finished run.
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (s4.load) begin
      mem[s4.addr] <= s4.value;
    end
    if (s4.emit && !s4.pad) begin
      rdata <= mem[s4.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5.emit <= 1'b0;
    end else begin
      s5.emit <= s4.emit;
    end
    s5.pad  <= s4.pad;
    s5.last <= s4.last;
  end

  // Result register: zero the value on a padded position.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= s5.emit;
    end
    out_value <= s5.pad ? '0 : rdata;
    padded    <= s5.pad;
    last      <= s5.last;
  end

endmodule

// File: sv/apr_checker.sv
// ----------------------------------------------------------------------------
// apr_checker: port-level checks for the axis permute reorder block
// Watches requests and results and checks their timing relation.
// ----------------------------------------------------------------------------
module apr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        cmd,
  input logic                        valid,
  input logic [apr_pkg::DATA_W-1:0]  out_value,
  input logic                        padded
);

  localparam int LAT = 6;

  // Hold the result channel quiet after reset.
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !valid)
    else $error("result shown right after reset");

  // Drop the value on a padded position.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && padded) |-> (out_value == '0))
    else $error("padded result carries a nonzero value");

  // Tie every result to an emit request a fixed latency earlier.
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(start && !busy && (cmd == apr_pkg::CMD_EMIT), LAT))
    else $error("result without a matching emit request");

  // Produce nothing for a load request.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == apr_pkg::CMD_LOAD)) |-> ##LAT !valid)
    else $error("load request produced a result");

endmodule

bind axis_permute_reorder apr_checker u_apr_checker (.*);

// File: tb/tb_axis_permute_reorder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axis_permute_reorder: self-checking bench for the axis permute reorder
// Drives load and emit requests with random gaps, keeps a cycle-free model of
// the fill count, odometer and element buffer, and checks every result strobe
// against the oldest predicted element. A short directed table comes first,
// then extreme extents, a full-buffer pass and random reorder phases.
// ----------------------------------------------------------------------------
module tb_axis_permute_reorder;
  import apr_pkg::*;

  localparam int                SETTLE_CYCLES = 10;       // result latency plus margin
  localparam int                LIMIT_CYCLES  = 400000;
  localparam int                RAND_ITEMS    = 950;
  localparam logic [EXT_W-1:0]  EXT_MAX       = 13'd4096;
  localparam logic [EXT_W-1:0]  EXT_ONE       = 13'd1;
  // stored axes 2 and 3 swapped
  localparam logic [MAP_W-1:0]  MAP_SWAP_LOW  = 12'd1224;
  // stored axis 3 absent, stored axis 2 takes caller axis 3
  localparam logic [MAP_W-1:0]  MAP_DROP_LAST = 12'd3784;
  // stored axes 0 and 1 swapped
  localparam logic [MAP_W-1:0]  MAP_SWAP_HIGH = 12'd1665;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              pad;
    logic              is_last;
  } elem_res_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   c;
    logic [DATA_W-1:0]      v;
    bit                     typed;
    elem_res_t              res;
  } stim_row_t;

  typedef enum int {STEP_IGNORED, STEP_LOADED, STEP_EMITTED} step_e;

  // --------------------------------------------------------------------------
  // DUT signals; every input holds a known value from time zero
  // --------------------------------------------------------------------------
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   start     = 1'b0;
  logic                   cmd       = CMD_LOAD;
  logic [DATA_W-1:0]      value     = '0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_EXTENT_0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   busy;
  logic                   valid;
  logic [DATA_W-1:0]      out_value;
  logic                   padded;
  logic                   last;

  axis_permute_reorder u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .value     (value),
    .valid     (valid),
    .out_value (out_value),
    .padded    (padded),
    .last      (last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of configuration, fill count, odometer
  // and buffer, advanced once per accepted request
  // --------------------------------------------------------------------------
  logic [EXT_W-1:0]   pred_ext [MAX_AXES];
  logic [MAP_W-1:0]   pred_map;
  int                 pred_fill;
  logic [CTR_W-1:0]   pred_pos [MAX_AXES];
  logic [DATA_W-1:0]  pred_mem [DEPTH_DEFAULT];

  elem_res_t          pending_elems [$];
  stim_row_t          dir_rows [$];

  int  errors       = 0;
  int  cycles       = 0;
  int  results_seen = 0;
  int  padded_seen  = 0;
  int  last_seen    = 0;
  int  taken_items  = 0;
  int  loads_taken  = 0;
  int  loads_dropped = 0;
  int  empty_emits  = 0;
  int  phases       = 0;
  bit  no_idle      = 1'b0;

  // Length of one stored axis: the mapped caller extent, or 1 when absent.
  function automatic logic [63:0] axis_len(input int ax);
    logic [FIELD_W-1:0] m;
    m = pred_map[FIELD_W*ax +: FIELD_W];
    return (m < MAX_AXES) ? 64'(pred_ext[m[1:0]]) : 64'd1;
  endfunction

  function automatic logic [63:0] stored_total();
    logic [63:0] t;
    t = 64'd1;
    for (int i = 0; i < MAX_AXES; i++) t = t * axis_len(i);
    return t;
  endfunction

  // Advance the model by one request; fill r when an element comes out.
  function automatic step_e next_reordered(input logic c, input logic [DATA_W-1:0] v,
                                           output elem_res_t r);
    logic [63:0]        stride [MAX_AXES];
    logic [63:0]        len [MAX_AXES];
    logic [63:0]        src;
    logic [63:0]        nxt;
    logic [FIELD_W-1:0] m;
    bit                 carry;
    r = '0;
    if (c == CMD_LOAD) begin
      // drop surplus loads once the buffer is full
      if (pred_fill >= DEPTH_DEFAULT) return STEP_IGNORED;
      pred_mem[pred_fill] = v;
      pred_fill++;
      return STEP_LOADED;
    end
    stride[MAX_AXES-1] = 64'd1;
    for (int i = MAX_AXES - 1; i > 0; i--) stride[i-1] = stride[i] * 64'(pred_ext[i]);
    for (int i = 0; i < MAX_AXES; i++) len[i] = axis_len(i);
    // empty emit: nothing to walk or nothing loaded
    if (stored_total() == 64'd0 || pred_fill == 0) return STEP_IGNORED;
    src = 64'd0;
    for (int i = 0; i < MAX_AXES; i++) begin
      m = pred_map[FIELD_W*i +: FIELD_W];
      if (m < MAX_AXES) src = src + 64'(pred_pos[i]) * stride[m[1:0]];
    end
    r.pad  = (src >= 64'(pred_fill));
    r.data = r.pad ? '0 : pred_mem[src[11:0]];
    // odometer, last stored axis fastest; out-of-range counters wrap and carry
    carry = 1'b1;
    for (int i = MAX_AXES - 1; i >= 0; i--) begin
      if (carry) begin
        nxt = 64'(pred_pos[i]) + 64'd1;
        if (nxt < len[i]) begin
          pred_pos[i] = nxt[CTR_W-1:0];
          carry = 1'b0;
        end else begin
          pred_pos[i] = '0;
        end
      end
    end
    r.is_last = carry;
    if (carry) begin
      pred_fill = 0;
      for (int i = 0; i < MAX_AXES; i++) pred_pos[i] = '0;
    end
    return STEP_EMITTED;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [EXT_W-1:0] pick_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 45) return EXT_ONE;
    if (r < 95) return EXT_W'($urandom_range(2, 4));
    return EXT_W'($urandom_range(5, 8));
  endfunction

  function automatic logic [MAP_W-1:0] random_perm();
    int          a [MAX_AXES];
    int          j;
    int          t;
    logic [MAP_W-1:0] m;
    for (int i = 0; i < MAX_AXES; i++) a[i] = i;
    for (int i = MAX_AXES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = a[i];
      a[i] = a[j];
      a[j] = t;
    end
    m = '0;
    for (int i = 0; i < MAX_AXES; i++) m[FIELD_W*i +: FIELD_W] = FIELD_W'(a[i]);
    return m;
  endfunction

  // Permutations mostly; also absent axes, repeated entries and raw bits.
  function automatic logic [MAP_W-1:0] pick_map();
    int          r;
    int          k;
    int          o;
    logic [MAP_W-1:0] m;
    r = $urandom_range(0, 99);
    m = random_perm();
    k = $urandom_range(0, MAX_AXES - 1);
    o = $urandom_range(0, MAX_AXES - 1);
    if (r < 70) return m;
    if (r < 85) begin
      m[FIELD_W*k +: FIELD_W] = FIELD_W'($urandom_range(MAX_AXES, 7));
      return m;
    end
    if (r < 92) begin
      m[FIELD_W*k +: FIELD_W] = m[FIELD_W*o +: FIELD_W];
      return m;
    end
    return MAP_W'($urandom);
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] i,
                                        input logic [CFG_DATA_W-1:0] d);
    stim_row_t s;
    s = '0;
    s.kind = ROW_CFG;
    s.idx  = i;
    s.data = d;
    return s;
  endfunction

  function automatic stim_row_t req_row(input logic c, input logic [DATA_W-1:0] v);
    stim_row_t s;
    s = '0;
    s.kind = ROW_REQ;
    s.c    = c;
    s.v    = v;
    return s;
  endfunction

  function automatic stim_row_t emit_exp(input logic [DATA_W-1:0] d, input logic p,
                                         input logic l);
    stim_row_t s;
    s = req_row(CMD_EMIT, '0);
    s.typed       = 1'b1;
    s.res.data    = d;
    s.res.pad     = p;
    s.res.is_last = l;
    return s;
  endfunction

  // Present one request, hold it until taken, then advance the model.
  task automatic issue(input logic c, input logic [DATA_W-1:0] v, input bit typed,
                       input elem_res_t typed_res);
    int        g;
    elem_res_t r;
    step_e     st;
    g = pick_gap();
    cfg_we <= 1'b0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    st = next_reordered(c, v, r);
    case (st)
      STEP_EMITTED: begin
        pending_elems.push_back(typed ? typed_res : r);
        taken_items++;
      end
      STEP_LOADED: begin
        loads_taken++;
        taken_items++;
      end
      default: begin
        if (c == CMD_LOAD) loads_dropped++;
        else empty_emits++;
      end
    endcase
  endtask

  // Drop start and wait until every predicted element has come out, then let
  // the pipeline drain loads that produce nothing.
  task automatic settle();
    start  <= 1'b0;
    cfg_we <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; cfg_we stays high until the next request or settle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    if (idx < MAX_AXES) pred_ext[idx[1:0]] = d;
    else if (idx == REG_AXIS_MAP) pred_map = d[MAP_W-1:0];
  endtask

  // Close any open walk: with every extent at 1 the next emit carries last.
  task automatic close_walk();
    settle();
    write_reg(REG_EXTENT_0, EXT_ONE);
    write_reg(REG_EXTENT_1, EXT_ONE);
    write_reg(REG_EXTENT_2, EXT_ONE);
    write_reg(REG_EXTENT_3, EXT_ONE);
    if (pred_fill == 0) issue(CMD_LOAD, rand64(), 1'b0, '0);
    issue(CMD_EMIT, '0, 1'b0, '0);
  endtask

  // One random phase: optional reconfiguration, then loads and emits sized to
  // the stored shape, either in order or interleaved with noise.
  task automatic random_phase();
    logic [63:0] total;
    int          tlen;
    int          nl;
    int          ne;
    int          r;
    bit          mixed;
    logic        c;
    settle();
    phases++;
    no_idle = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) != 0) begin
      write_reg(REG_EXTENT_0, pick_extent());
      write_reg(REG_EXTENT_1, pick_extent());
      write_reg(REG_EXTENT_2, pick_extent());
      write_reg(REG_EXTENT_3, pick_extent());
      write_reg(REG_AXIS_MAP, {1'($urandom), pick_map()});
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_AXIS_MAP) + 1, 7)),
                  CFG_DATA_W'($urandom));
    end
    total = stored_total();
    tlen  = (total > 64'd64) ? 64 : int'(total);
    r = $urandom_range(0, 99);
    if (r < 70) nl = tlen;
    else if (r < 85) nl = $urandom_range(0, tlen);
    else nl = tlen + $urandom_range(1, 4);
    ne = ($urandom_range(0, 99) < 75) ? tlen : $urandom_range(0, tlen + 3);
    mixed = ($urandom_range(0, 4) == 0);
    if (mixed) begin
      while (nl > 0 || ne > 0) begin
        c = (ne == 0 || (nl > 0 && $urandom_range(0, 1) == 0)) ? CMD_LOAD : CMD_EMIT;
        if (c == CMD_LOAD) nl--;
        else ne--;
        if ($urandom_range(0, 19) == 0) c = 1'($urandom);
        issue(c, rand64(), 1'b0, '0);
      end
    end else begin
      repeat (nl) issue(CMD_LOAD, rand64(), 1'b0, '0);
      if ($urandom_range(0, 9) == 0) settle();
      repeat (ne) issue(CMD_EMIT, rand64(), 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker: compare each strobe with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    elem_res_t e;
    if (!rst && valid) begin
      if (pending_elems.size() == 0) begin
        $display("[%0t] unexpected result: out_value %h padded %b last %b",
                 $time, out_value, padded, last);
        errors++;
      end else begin
        e = pending_elems.pop_front();
        results_seen++;
        if (padded) padded_seen++;
        if (last) last_seen++;
        if (out_value !== e.data) begin
          $display("[%0t] out_value mismatch: expected %h, actual %h", $time, e.data,
                   out_value);
          errors++;
        end
        if (padded !== e.pad) begin
          $display("[%0t] padded mismatch: expected %b, actual %b", $time, e.pad, padded);
          errors++;
        end
        if (last !== e.is_last) begin
          $display("[%0t] last mismatch: expected %b, actual %b", $time, e.is_last, last);
          errors++;
        end
      end
    end
  end

  // Hard stop if the run hangs on a missing result or a stuck busy.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[%0t] timeout with %0d results outstanding", $time, pending_elems.size());
      $display("axis_permute_reorder verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int base_items;
    bit prev_cfg;

    for (int i = 0; i < MAX_AXES; i++) begin
      pred_ext[i] = EXT_RESET;
      pred_pos[i] = '0;
    end
    pred_map  = MAP_RESET;
    pred_fill = 0;

    // Directed table. Reset state: every extent 1, identity map, a one-element
    // shape, so each emit after a single load is the final element.
    dir_rows.push_back(req_row(CMD_EMIT, '0));                   // nothing loaded yet
    dir_rows.push_back(req_row(CMD_LOAD, '1));
    dir_rows.push_back(emit_exp('1, 1'b0, 1'b1));
    dir_rows.push_back(req_row(CMD_LOAD, '0));
    dir_rows.push_back(emit_exp('0, 1'b0, 1'b1));
    // 2 x 3 shape with only four elements: the tail comes out padded
    dir_rows.push_back(cfg_row(REG_EXTENT_3, 13'd3));
    dir_rows.push_back(cfg_row(REG_EXTENT_2, 13'd2));
    dir_rows.push_back(req_row(CMD_LOAD, 64'h0123_4567_89AB_CDEF));
    dir_rows.push_back(req_row(CMD_LOAD, 64'h8000_0000_0000_0000));
    dir_rows.push_back(req_row(CMD_LOAD, 64'h0000_0000_0000_0001));
    dir_rows.push_back(req_row(CMD_LOAD, 64'hA5A5_5A5A_C3C3_3C3C));
    dir_rows.push_back(req_row(CMD_EMIT, '0));
    dir_rows.push_back(req_row(CMD_EMIT, '0));
    dir_rows.push_back(req_row(CMD_EMIT, '0));
    dir_rows.push_back(req_row(CMD_EMIT, '0));
    dir_rows.push_back(emit_exp('0, 1'b1, 1'b0));
    dir_rows.push_back(emit_exp('0, 1'b1, 1'b1));
    // transpose the two fast axes and stop partway through the walk
    dir_rows.push_back(cfg_row(REG_AXIS_MAP, MAP_SWAP_LOW));
    dir_rows.push_back(req_row(CMD_LOAD, 64'hDEAD_BEEF_0000_FFFF));
    dir_rows.push_back(req_row(CMD_LOAD, 64'h7FFF_FFFF_FFFF_FFFE));
    dir_rows.push_back(req_row(CMD_LOAD, 64'h5555_AAAA_5555_AAAA));
    dir_rows.push_back(req_row(CMD_EMIT, '0));
    dir_rows.push_back(req_row(CMD_EMIT, '0));
    dir_rows.push_back(req_row(CMD_EMIT, '0));
    // a zero extent empties the shape: the emit gives nothing
    dir_rows.push_back(cfg_row(REG_EXTENT_0, 13'd0));
    dir_rows.push_back(req_row(CMD_EMIT, '0));
    // absent stored axis while counters sit past the new lengths
    dir_rows.push_back(cfg_row(REG_EXTENT_0, EXT_ONE));
    dir_rows.push_back(cfg_row(REG_AXIS_MAP, MAP_DROP_LAST));
    dir_rows.push_back(req_row(CMD_EMIT, '0));
    dir_rows.push_back(req_row(CMD_EMIT, '0));
    dir_rows.push_back(req_row(CMD_EMIT, '0));

    // hold reset, then release it for good
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    prev_cfg = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!prev_cfg) settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        prev_cfg = 1'b1;
      end else begin
        issue(dir_rows[i].c, dir_rows[i].v, dir_rows[i].typed, dir_rows[i].res);
        prev_cfg = 1'b0;
      end
    end

    // Largest extents on every axis: strides reach far past the buffer, so
    // most emits pad. The walk stays open until close_walk ends it.
    settle();
    write_reg(REG_EXTENT_0, EXT_MAX);
    write_reg(REG_EXTENT_1, EXT_MAX);
    write_reg(REG_EXTENT_2, EXT_MAX);
    write_reg(REG_EXTENT_3, EXT_MAX);
    write_reg(REG_AXIS_MAP, {1'b1, random_perm()});
    repeat (12) issue(CMD_LOAD, rand64(), 1'b0, '0);
    repeat (30) issue(CMD_EMIT, '0, 1'b0, '0);

    // Full buffer: fill past DEPTH so surplus loads drop, pause until the
    // pipeline is empty, then read all 4096 entries back transposed.
    close_walk();
    settle();
    write_reg(REG_EXTENT_0, 13'd64);
    write_reg(REG_EXTENT_1, 13'd64);
    write_reg(REG_EXTENT_2, EXT_ONE);
    write_reg(REG_EXTENT_3, EXT_ONE);
    write_reg(REG_AXIS_MAP, MAP_SWAP_HIGH);
    repeat (DEPTH_DEFAULT + 5) issue(CMD_LOAD, rand64(), 1'b0, '0);
    settle();
    repeat (DEPTH_DEFAULT) issue(CMD_EMIT, rand64(), 1'b0, '0);

    // Random reorder phases until enough requests have had an effect.
    base_items = taken_items;
    while (taken_items - base_items < RAND_ITEMS) begin
      if ($urandom_range(0, 19) == 0) close_walk();
      random_phase();
    end

    no_idle = 1'b0;
    settle();

    $display("covered %0d phases: %0d loads taken, %0d dropped, %0d empty emits",
             phases, loads_taken, loads_dropped, empty_emits);
    $display("checked %0d results, %0d padded, %0d carrying last; %0d errors",
             results_seen, padded_seen, last_seen, errors);
    if (errors == 0) begin
      $display("axis_permute_reorder verification clean");
    end else begin
      $display("axis_permute_reorder verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/apr_pkg.sv
sv/axis_permute_reorder.sv
sv/apr_checker.sv
tb/tb_axis_permute_reorder.sv
